// ===== hdl/fse_pkg.sv =====
// Package for the floored stack engine: sizes, opcodes, status codes,
// state encoding and the memory command and decode structures.
// No dependencies.
package fse_pkg;

   localparam int DEPTH      = 256;
   localparam int WORD_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int PTR_W      = ADDR_W + 1;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 3;
   localparam int INDEX_W    = 8;
   localparam int COUNT_W    = 9;
   localparam int CAP_W      = 9;
   localparam int CAP_RESET  = 256;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 3'd0,
      OP_POP  = 3'd1,
      OP_GET  = 3'd2,
      OP_PUT  = 3'd3,
      OP_LIFT = 3'd4,
      OP_SWAP = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_PUSH_FULL  = 3'd1,
      ST_POP_EMPTY  = 3'd2,
      ST_RANGE      = 3'd3,
      ST_LIFT_REFUSED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RESP,
      S_SWAP_B,
      S_SWAP_WA,
      S_SWAP_WB
   } state_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  rd_en;
      logic [ADDR_W-1:0]     addr;
      logic [WORD_WIDTH-1:0] wdata;
   } mem_cmd_type;

   typedef struct packed {
      status_type        status;
      logic              warn;
      logic              read_result;
      logic [PTR_W-1:0]  top;
      logic [PTR_W-1:0]  floor_ptr;
      mem_cmd_type       cmd;
   } decode_type;

endpackage

// ===== hdl/fse_if.sv =====
// Valid/ready channels of the floored stack engine: request and response.
// Depends on fse_pkg.
interface fse_req_if;
   logic                            valid;
   logic                            ready;
   logic [fse_pkg::OP_W-1:0]        opcode;
   logic [fse_pkg::WORD_WIDTH-1:0]  value;
   logic [fse_pkg::INDEX_W-1:0]     index_a;
   logic [fse_pkg::INDEX_W-1:0]     index_b;

   modport source (output valid, output opcode, output value, output index_a,
                   output index_b, input ready);
   modport sink   (input valid, input opcode, input value, input index_a,
                   input index_b, output ready);
endinterface

interface fse_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [fse_pkg::WORD_WIDTH-1:0]  read_data;
   logic [fse_pkg::STATUS_W-1:0]    status;
   logic                            below_floor;
   logic [fse_pkg::COUNT_W-1:0]     top_count;
   logic [fse_pkg::COUNT_W-1:0]     floor_level;
   logic                            is_full;
   logic                            is_empty;

   modport source (output valid, output read_data, output status, output below_floor,
                   output top_count, output floor_level, output is_full,
                   output is_empty, input ready);
   modport sink   (input valid, input read_data, input status, input below_floor,
                   input top_count, input floor_level, input is_full,
                   input is_empty, output ready);
endinterface

// ===== hdl/floored_stack_engine_core.sv =====
// Floored stack engine top level: control, pointers and the stack memory.
// Depends on fse_pkg and the channel interfaces in fse_if.sv.
//
// A word stack held in a single-port synchronous memory of 256 x 32 bits, with a top
// pointer and a movable floor (the foundation is always entry 0). One request transfer
// carries one opcode (push, pop, get, put, lift, swap) and gives exactly one response
// transfer with read data, status, the pointers after the operation and the full and
// empty flags. Items are handled one at a time: a request is taken only in S_IDLE, once
// the response register is empty or being taken in the same cycle. Push, pop, get, put,
// lift and the unused opcodes pass through S_RESP; swap passes through S_SWAP_B,
// S_SWAP_WA and S_SWAP_WB, since the memory port does one access per cycle and a swap
// needs two reads and two writes. Capacity is written through
// csr_write_enable/csr_write_data; the user must write it only while the block is idle
// (not enforced by the block). It resets to 256 and values above 256 act as 256. Memory
// contents are not cleared at reset; reading an entry never written returns garbage.
module floored_stack_engine_core (
   input  logic                        clock,
   input  logic                        reset,
   fse_req_if.sink                     req,
   fse_rsp_if.source                   rsp,
   input  logic                        csr_write_enable,
   input  logic [fse_pkg::CAP_W-1:0]   csr_write_data
);

   // ---------------------------------------------------------------
   // State
   // ---------------------------------------------------------------
   fse_pkg::state_type                 state_ff, state_in;
   logic [fse_pkg::PTR_W-1:0]          top_ff, floor_ff;
   logic [fse_pkg::CAP_W-1:0]          capacity_ff;

   // context of the item in flight
   fse_pkg::status_type                status_ff;
   logic                               warn_ff;
   logic                               read_result_ff;
   logic [fse_pkg::ADDR_W-1:0]         index_a_ff, index_b_ff;
   logic [fse_pkg::WORD_WIDTH-1:0]     hold_ff;

   // stack memory, one port, registered read
   logic [fse_pkg::WORD_WIDTH-1:0]     stack_mem [fse_pkg::DEPTH];
   logic [fse_pkg::WORD_WIDTH-1:0]     mem_rdata_ff;
   fse_pkg::mem_cmd_type               mem_cmd;

   // response register
   logic                               rsp_valid_ff;
   logic [fse_pkg::WORD_WIDTH-1:0]     rsp_read_data_ff;
   fse_pkg::status_type                rsp_status_ff;
   logic                               rsp_below_floor_ff;
   logic [fse_pkg::COUNT_W-1:0]        rsp_top_count_ff, rsp_floor_level_ff;
   logic                               rsp_is_full_ff, rsp_is_empty_ff;

   // ---------------------------------------------------------------
   // Control terms
   // ---------------------------------------------------------------
   fse_pkg::opcode_type                op_sel;
   fse_pkg::decode_type                dec;
   logic [fse_pkg::PTR_W-1:0]          eff_cap;
   logic [fse_pkg::PTR_W-1:0]          index_a_ext;
   logic                               req_ready_c;
   logic                               req_accept;
   logic                               finish;
   logic                               hold_load;

   assign op_sel      = fse_pkg::opcode_type'(req.opcode);
   assign index_a_ext = fse_pkg::PTR_W'(req.index_a);

   // capacity above the store depth acts as the depth
   assign eff_cap = (capacity_ff > fse_pkg::CAP_W'(fse_pkg::DEPTH))
                    ? fse_pkg::PTR_W'(fse_pkg::DEPTH)
                    : fse_pkg::PTR_W'(capacity_ff);

   assign req_ready_c = (state_ff == fse_pkg::S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_accept  = req.valid && req_ready_c;
   assign req.ready   = req_ready_c;

   // ---------------------------------------------------------------
   // Request decode: bounds checks against the current pointers,
   // pointer updates and the first memory access of the item.
   // ---------------------------------------------------------------
   always_comb begin
      dec             = '0;
      dec.status      = fse_pkg::ST_OK;
      dec.top         = top_ff;
      dec.floor_ptr   = floor_ff;
      dec.cmd.addr    = req.index_a;
      dec.cmd.wdata   = req.value;
      case (op_sel)
         fse_pkg::OP_PUSH: begin
            // full also covers a capacity lowered below top
            if (top_ff >= eff_cap) begin
               dec.status = fse_pkg::ST_PUSH_FULL;
            end else begin
               dec.cmd.wr_en = 1'b1;
               dec.cmd.addr  = top_ff[fse_pkg::ADDR_W-1:0];
               dec.top       = top_ff + fse_pkg::PTR_W'(1);
            end
         end
         fse_pkg::OP_POP: begin
            if (top_ff <= floor_ff) begin
               dec.status = fse_pkg::ST_POP_EMPTY;
            end else begin
               dec.top         = top_ff - fse_pkg::PTR_W'(1);
               dec.cmd.rd_en   = 1'b1;
               dec.cmd.addr    = dec.top[fse_pkg::ADDR_W-1:0];
               dec.read_result = 1'b1;
            end
         end
         fse_pkg::OP_GET, fse_pkg::OP_PUT: begin
            // below-floor access is served, only flagged
            dec.warn = (index_a_ext < floor_ff);
            if (index_a_ext < top_ff) begin
               if (op_sel == fse_pkg::OP_GET) begin
                  dec.cmd.rd_en   = 1'b1;
                  dec.read_result = 1'b1;
               end else begin
                  dec.cmd.wr_en = 1'b1;
               end
            end else begin
               dec.status = fse_pkg::ST_RANGE;
            end
         end
         fse_pkg::OP_LIFT: begin
            if (floor_ff >= top_ff) begin
               dec.status = fse_pkg::ST_LIFT_REFUSED;
            end else begin
               dec.floor_ptr = floor_ff + fse_pkg::PTR_W'(1);
            end
         end
         fse_pkg::OP_SWAP: begin
            // read entry a now, entry b next cycle, then write both back
            dec.cmd.rd_en = 1'b1;
         end
         default: begin
            // unused opcodes change nothing
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fse_pkg::S_IDLE: begin
            if (req_accept) begin
               state_in = (op_sel == fse_pkg::OP_SWAP) ? fse_pkg::S_SWAP_B
                                                       : fse_pkg::S_RESP;
            end
         end
         fse_pkg::S_RESP:    state_in = fse_pkg::S_IDLE;
         fse_pkg::S_SWAP_B:  state_in = fse_pkg::S_SWAP_WA;
         fse_pkg::S_SWAP_WA: state_in = fse_pkg::S_SWAP_WB;
         fse_pkg::S_SWAP_WB: state_in = fse_pkg::S_IDLE;
         default:            state_in = fse_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer: memory access and response load per state
   // ---------------------------------------------------------------
   always_comb begin
      mem_cmd   = '0;
      finish    = 1'b0;
      hold_load = 1'b0;
      case (state_ff)
         fse_pkg::S_IDLE: begin
            if (req_accept) begin
               mem_cmd = dec.cmd;
            end
         end
         fse_pkg::S_RESP: begin
            // pop/get data lands in mem_rdata_ff this cycle
            finish = 1'b1;
         end
         fse_pkg::S_SWAP_B: begin
            // entry a arrives, entry b is read
            mem_cmd.rd_en = 1'b1;
            mem_cmd.addr  = index_b_ff;
            hold_load     = 1'b1;
         end
         fse_pkg::S_SWAP_WA: begin
            // old b into a
            mem_cmd.wr_en = 1'b1;
            mem_cmd.addr  = index_a_ff;
            mem_cmd.wdata = mem_rdata_ff;
         end
         fse_pkg::S_SWAP_WB: begin
            // old a into b; same index works out to no change
            mem_cmd.wr_en = 1'b1;
            mem_cmd.addr  = index_b_ff;
            mem_cmd.wdata = hold_ff;
            finish        = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Stack memory. Accesses are strictly serialized by the sequencer,
   // so a read never overlaps a pending write.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         stack_mem[mem_cmd.addr] <= mem_cmd.wdata;
      end
      if (mem_cmd.rd_en) begin
         mem_rdata_ff <= stack_mem[mem_cmd.addr];
      end
   end

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fse_pkg::S_IDLE;
         top_ff       <= '0;
         floor_ff     <= '0;
         capacity_ff  <= fse_pkg::CAP_W'(fse_pkg::CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            top_ff   <= dec.top;
            floor_ff <= dec.floor_ptr;
         end
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Item context and response payload
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff      <= dec.status;
         warn_ff        <= dec.warn;
         read_result_ff <= dec.read_result;
         index_a_ff     <= req.index_a;
         index_b_ff     <= req.index_b;
      end
      if (hold_load) begin
         hold_ff <= mem_rdata_ff;
      end
      if (finish) begin
         // pointers were updated at the request transfer
         rsp_read_data_ff   <= read_result_ff ? mem_rdata_ff : '0;
         rsp_status_ff      <= status_ff;
         rsp_below_floor_ff <= warn_ff;
         rsp_top_count_ff   <= fse_pkg::COUNT_W'(top_ff);
         rsp_floor_level_ff <= fse_pkg::COUNT_W'(floor_ff);
         rsp_is_full_ff     <= (top_ff >= eff_cap);
         rsp_is_empty_ff    <= (top_ff == floor_ff);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.read_data   = rsp_read_data_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.below_floor = rsp_below_floor_ff;
   assign rsp.top_count   = rsp_top_count_ff;
   assign rsp.floor_level = rsp_floor_level_ff;
   assign rsp.is_full     = rsp_is_full_ff;
   assign rsp.is_empty    = rsp_is_empty_ff;

endmodule

// ===== hdl/fse_checker.sv =====
// Port-level checks for floored_stack_engine_core, attached with bind.
// Depends on fse_pkg.
module fse_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [fse_pkg::WORD_WIDTH-1:0]    rsp_read_data,
   input logic [fse_pkg::STATUS_W-1:0]      rsp_status,
   input logic [fse_pkg::COUNT_W-1:0]       rsp_top_count,
   input logic [fse_pkg::COUNT_W-1:0]       rsp_floor_level,
   input logic                              rsp_is_empty
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                 && $stable(rsp_status) && $stable(rsp_top_count))
      else $error("response changed while stalled");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   a_floor_le_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_floor_level <= rsp_top_count)
      else $error("floor above top");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_empty == (rsp_top_count == rsp_floor_level))
      else $error("empty flag disagrees with pointers");

   // refused operations return no data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != fse_pkg::STATUS_W'(fse_pkg::ST_OK)) |->
         rsp_read_data == '0)
      else $error("read data on refused operation");

endmodule

bind floored_stack_engine_core fse_checker u_fse_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_read_data   (rsp.read_data),
   .rsp_status      (rsp.status),
   .rsp_top_count   (rsp.top_count),
   .rsp_floor_level (rsp.floor_level),
   .rsp_is_empty    (rsp.is_empty)
);
